### src/mrm_pkg.sv
// Package: payload structs, codes and CRC helper for the Modbus RTU register master.
package mrm_pkg;

   localparam int TimerBitsDefault = 16;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_BYTE  = 2'd2,
      FUNC_TICK  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_TIMEOUT = 2'd1,
      ST_CRC     = 2'd2,
      ST_FRAME   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_DEV_ADDR  = 2'd0,
      CSR_TIMEOUT   = 2'd1,
      CSR_MAX_ATT   = 2'd2,
      CSR_RETRY_GAP = 2'd3
   } csr_idx_type;

   localparam logic [7:0] FC_READ  = 8'h03;
   localparam logic [7:0] FC_WRITE = 8'h06;
   localparam logic [7:0] BYTE_CNT = 8'h02;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] target_addr;
      logic [15:0] write_value;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [1:0]  status;
      logic [15:0] read_value;
      logic [2:0]  attempts_used;
   } rsp_type;

   // Command from engine to frame emitter.
   typedef struct packed {
      logic        send;       // emit 8-byte request
      logic        done;       // emit one result
      rsp_type     res;        // result for done
      logic [7:0]  dev;
      logic        is_write;
      logic [15:0] target_addr;
      logic [15:0] data;
   } cmd_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### src/mrm_engine.sv
// Front part: classifies items, runs the transaction state and queues commands.
module mrm_engine
   import mrm_pkg::*;
#(
   parameter int TIMER_BITS = TimerBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_stall,
   input  req_type     in_data,
   input  logic [7:0]  dev_addr,
   input  logic [15:0] timeout_ticks,
   input  logic [2:0]  max_attempts,
   input  logic [15:0] retry_gap,
   output logic        cmd_valid,
   input  logic        cmd_take,
   output cmd_type     cmd_data
);

   typedef enum logic [1:0] {PH_IDLE, PH_AWAIT, PH_GAP} phase_type;

   localparam logic [TIMER_BITS-1:0] TMax = {TIMER_BITS{1'b1}};
   // compare width covers both the timer and the 16-bit settings
   localparam int CmpBits = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   phase_type             phase_ff;
   logic                  wr_ff;
   logic [15:0]           reg_ff, data_ff;
   logic [7:0]            store_ff [8];
   logic [3:0]            cnt_ff;
   logic [TIMER_BITS-1:0] timer_ff;
   logic [2:0]            att_ff;
   logic [15:0]           crc_ff;

   // two-entry command queue
   cmd_type               q_ff [2];
   logic [1:0]            qn_ff;

   logic accept;
   assign in_stall = (qn_ff == 2'd2);
   assign accept = in_valid && !in_stall;
   assign cmd_valid = (qn_ff != 2'd0);
   assign cmd_data = q_ff[0];

   logic [2:0] max_eff;
   assign max_eff = (max_attempts == 3'd0) ? 3'd1 : max_attempts;

   // combinational step
   phase_type             phase_in;
   logic                  wr_in;
   logic [15:0]           reg_in, data_in, crc_in;
   logic [3:0]            cnt_in;
   logic [TIMER_BITS-1:0] timer_in, tnext;
   logic [2:0]            att_in;
   logic                  push;
   cmd_type               c;
   logic                  judge, fail_f;
   status_type            fst;
   logic [3:0]            need;
   logic [15:0]           got;
   logic [7:0]            b0, b1, b2, b3;
   logic                  gap_hit;

   always_comb begin
      phase_in = phase_ff;
      wr_in = wr_ff;
      reg_in = reg_ff;
      data_in = data_ff;
      cnt_in = cnt_ff;
      timer_in = timer_ff;
      att_in = att_ff;
      crc_in = crc_ff;
      push = 1'b0;
      c = '0;
      judge = 1'b0;
      fail_f = 1'b0;
      fst = ST_OK;
      need = wr_ff ? 4'd8 : 4'd7;
      got = '0;
      b0 = store_ff[0];
      b1 = store_ff[1];
      b2 = store_ff[2];
      b3 = store_ff[3];
      tnext = (timer_ff == TMax) ? timer_ff : timer_ff + 1'b1;
      gap_hit = 1'b0;
      if (accept) begin
         unique case (func_type'(in_data.func))
            FUNC_READ, FUNC_WRITE: begin
               push = 1'b1;
               if (phase_ff != PH_IDLE) begin
                  c.done = 1'b1;
                  c.res.kind = KIND_REJECT;
               end else begin
                  wr_in = in_data.func[0];
                  reg_in = in_data.target_addr;
                  data_in = in_data.func[0] ? in_data.write_value : 16'h0000;
                  c.send = 1'b1;
                  att_in = 3'd1;
                  phase_in = PH_AWAIT;
                  cnt_in = '0;
                  crc_in = CRC_INIT;
                  timer_in = '0;
               end
            end
            FUNC_BYTE: begin
               if (phase_ff == PH_AWAIT) begin
                  if (cnt_ff < need - 4'd2) crc_in = crc_feed(crc_ff, in_data.rx_byte);
                  cnt_in = cnt_ff + 4'd1;
                  if (cnt_in == need) begin
                     judge = 1'b1;
                     // CRC bytes: last byte is the current one
                     got = wr_ff ? {in_data.rx_byte, store_ff[6]}
                                 : {in_data.rx_byte, store_ff[5]};
                     if (got != crc_ff) begin
                        fail_f = 1'b1; fst = ST_CRC;
                     end else if (b0 != dev_addr || b1 != (wr_ff ? FC_WRITE : FC_READ)) begin
                        fail_f = 1'b1; fst = ST_FRAME;
                     end else if (!wr_ff && b2 != BYTE_CNT) begin
                        fail_f = 1'b1; fst = ST_FRAME;
                     end else begin
                        push = 1'b1;
                        c.done = 1'b1;
                        c.res.kind = KIND_DONE;
                        c.res.status = ST_OK;
                        c.res.read_value = wr_ff ? 16'h0000 : {b3, store_ff[4]};
                        c.res.attempts_used = att_ff;
                        phase_in = PH_IDLE;
                     end
                  end
               end
            end
            FUNC_TICK: begin
               if (phase_ff == PH_AWAIT) begin
                  timer_in = tnext;
                  if (CmpBits'(tnext) > CmpBits'(timeout_ticks) || tnext == TMax) begin
                     fail_f = 1'b1; fst = ST_TIMEOUT;
                  end
               end else if (phase_ff == PH_GAP) begin
                  timer_in = tnext;
                  if (CmpBits'(tnext) >= CmpBits'(retry_gap) || tnext == TMax)
                     gap_hit = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (fail_f) begin
         if (!wr_ff && att_ff < max_eff) begin
            if (retry_gap == 16'h0000) begin
               gap_hit = 1'b1;
            end else begin
               phase_in = PH_GAP;
               timer_in = '0;
               cnt_in = '0;
            end
         end else begin
            push = 1'b1;
            c.done = 1'b1;
            c.res.kind = KIND_DONE;
            c.res.status = fst;
            c.res.attempts_used = att_ff;
            phase_in = PH_IDLE;
         end
      end
      if (gap_hit) begin
         push = 1'b1;
         c.send = 1'b1;
         att_in = att_ff + 3'd1;
         phase_in = PH_AWAIT;
         cnt_in = '0;
         crc_in = CRC_INIT;
         timer_in = '0;
      end
      c.dev = dev_addr;
      c.is_write = wr_in;
      c.target_addr = reg_in;
      c.data = data_in;
   end

   logic pop;
   assign pop = cmd_valid && cmd_take;

   // new command goes to the head when the queue is empty or its only entry leaves
   logic push_head;
   assign push_head = push && (qn_ff == 2'd0 || (qn_ff == 2'd1 && pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wr_ff <= 1'b0;
         reg_ff <= '0;
         data_ff <= '0;
         cnt_ff <= '0;
         timer_ff <= '0;
         att_ff <= '0;
         crc_ff <= CRC_INIT;
         qn_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         wr_ff <= wr_in;
         reg_ff <= reg_in;
         data_ff <= data_in;
         cnt_ff <= cnt_in;
         timer_ff <= timer_in;
         att_ff <= att_in;
         crc_ff <= crc_in;
         qn_ff <= qn_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_data.func == FUNC_BYTE && phase_ff == PH_AWAIT && !judge)
         store_ff[cnt_ff[2:0]] <= in_data.rx_byte;
      if (push_head) q_ff[0] <= c;
      else if (pop) q_ff[0] <= q_ff[1];
      if (push && !push_head) q_ff[1] <= c;
   end

endmodule

### src/mrm_emitter.sv
// Back part: turns queued commands into request bytes or results, with an output register.
module mrm_emitter
   import mrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_take,
   input  cmd_type cmd_data,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic        busy_ff;
   logic [2:0]  idx_ff;
   logic [7:0]  frame_ff [8];
   logic        ov_ff;
   rsp_type     od_ff;
   logic [7:0]  f [8];
   logic [15:0] crc;
   logic        slot;
   rsp_type     byte_rsp;

   assign out_valid = ov_ff;
   assign out_data = od_ff;
   assign slot = !ov_ff || !out_stall;
   assign cmd_take = !busy_ff && slot;

   always_comb begin
      f[0] = cmd_data.dev;
      f[1] = cmd_data.is_write ? FC_WRITE : FC_READ;
      f[2] = cmd_data.target_addr[15:8];
      f[3] = cmd_data.target_addr[7:0];
      f[4] = cmd_data.is_write ? cmd_data.data[15:8] : 8'h00;
      f[5] = cmd_data.is_write ? cmd_data.data[7:0] : 8'h01;
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) crc = crc_feed(crc, f[i]);
      f[6] = crc[7:0];
      f[7] = crc[15:8];
      // next request byte: first byte of a new frame, or the next stored one
      byte_rsp = '0;
      byte_rsp.kind = KIND_TX;
      byte_rsp.tx_byte = busy_ff ? frame_ff[idx_ff] : f[0];
      byte_rsp.last = busy_ff && (idx_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         ov_ff <= 1'b0;
      end else if (slot) begin
         if (busy_ff) begin
            ov_ff <= 1'b1;
            od_ff <= byte_rsp;
            idx_ff <= idx_ff + 3'd1;
            if (idx_ff == 3'd7) busy_ff <= 1'b0;
         end else if (cmd_valid) begin
            ov_ff <= 1'b1;
            if (cmd_data.send) begin
               for (int i = 0; i < 8; i++) frame_ff[i] <= f[i];
               od_ff <= byte_rsp;
               idx_ff <= 3'd1;
               busy_ff <= 1'b1;
            end else begin
               od_ff <= cmd_data.res;
            end
         end else begin
            ov_ff <= 1'b0;
         end
      end
   end

endmodule

### src/modbus_rtu_register_master.sv
// Top level of the Modbus RTU register master.
// A result or the first request byte passes through the command queue and then the output register.
// A start yields eight request-byte transfers, one per cycle while the receiver takes them.
// Inputs are taken one per cycle until the two-entry command queue fills; each start then
// holds the frame emitter until all eight request bytes have been sent.
// Synchronous active-high reset: idle, registers at 1, 500, 3, 50.
module modbus_rtu_register_master
   import mrm_pkg::*;
#(
   parameter int TIMER_BITS = TimerBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [7:0]  dev_ff;
   logic [15:0] tmo_ff, gap_ff;
   logic [2:0]  att_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= 8'd1;
         tmo_ff <= 16'd500;
         att_ff <= 3'd3;
         gap_ff <= 16'd50;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_DEV_ADDR:  dev_ff <= csr_wdata[7:0];
            CSR_TIMEOUT:   tmo_ff <= csr_wdata;
            CSR_MAX_ATT:   att_ff <= csr_wdata[2:0];
            CSR_RETRY_GAP: gap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   mrm_engine #(.TIMER_BITS(TIMER_BITS)) u_engine (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_data(req_data),
      .dev_addr(dev_ff), .timeout_ticks(tmo_ff), .max_attempts(att_ff),
      .retry_gap(gap_ff),
      .cmd_valid, .cmd_take, .cmd_data
   );

   mrm_emitter u_emitter (
      .clock, .reset,
      .cmd_valid, .cmd_take, .cmd_data,
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_data(rsp_data)
   );

   a_last_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.kind == KIND_TX)
      else $error("last set on non-transmit result");
   a_take_slot: assert property (@(posedge clock) disable iff (reset)
      cmd_take && cmd_valid |=> rsp_valid)
      else $error("command taken without output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

### tb/sv/tb_modbus_rtu_register_master.sv
// Testbench for the Modbus RTU register master: directed table, then random transactions.
module tb_modbus_rtu_register_master;
   import mrm_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_AWAIT, PH_GAP} phase_type;

   typedef struct {
      req_type d;
      bit      chk;
      rsp_type first;
   } stim_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   modbus_rtu_register_master dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // configuration copy
   logic [7:0]  cfg_dev;
   logic [15:0] cfg_timeout;
   logic [2:0]  cfg_att;
   logic [15:0] cfg_gap;

   // transaction state copy
   phase_type   m_phase;
   bit          m_write;
   logic [15:0] m_reg;
   logic [15:0] m_data;
   logic [7:0]  m_store [8];
   logic [3:0]  m_cnt;
   logic [15:0] m_timer;
   logic [2:0]  m_att;
   logic [15:0] m_crc;

   rsp_type  expected_rsp_q [$];
   stim_type stim_q [$];
   stim_type cur;
   int       errors = 0;
   int       hold_cycles = 0;
   int       burst_left = 0;
   int       gap_left = 0;
   int       stall_mode = 0;
   int       mode_left = 0;
   int       hold_left = 0;
   longint   cycles = 0;

   function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] x;
      x = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
      end
      return x;
   endfunction

   function automatic void push_rsp(kind_type k, logic [7:0] tx, logic l, status_type s,
                                    logic [15:0] v, logic [2:0] a);
      rsp_type r;
      r.kind = k;
      r.tx_byte = tx;
      r.last = l;
      r.status = s;
      r.read_value = v;
      r.attempts_used = a;
      expected_rsp_q.push_back(r);
   endfunction

   function automatic void emit_frame();
      logic [7:0]  f [8];
      logic [15:0] c;
      f[0] = cfg_dev;
      f[1] = m_write ? FC_WRITE : FC_READ;
      f[2] = m_reg[15:8];
      f[3] = m_reg[7:0];
      f[4] = m_write ? m_data[15:8] : 8'h00;
      f[5] = m_write ? m_data[7:0] : 8'h01;
      c = CRC_INIT;
      for (int i = 0; i < 6; i++) c = crc16_byte(c, f[i]);
      f[6] = c[7:0];
      f[7] = c[15:8];
      for (int i = 0; i < 8; i++) push_rsp(KIND_TX, f[i], i == 7, ST_OK, 16'h0, 3'd0);
      m_att = m_att + 3'd1;
      m_phase = PH_AWAIT;
      m_cnt = '0;
      m_crc = CRC_INIT;
      m_timer = '0;
   endfunction

   function automatic void end_txn(status_type s, logic [15:0] v);
      push_rsp(KIND_DONE, 8'h00, 1'b0, s, v, m_att);
      m_phase = PH_IDLE;
   endfunction

   function automatic void fail_txn(status_type s);
      if (!m_write && m_att < cfg_att) begin
         if (cfg_gap == 16'h0) emit_frame();
         else begin
            m_phase = PH_GAP;
            m_timer = '0;
            m_cnt = '0;
         end
      end else end_txn(s, 16'h0);
   endfunction

   function automatic void take_rx(logic [7:0] b);
      logic [3:0]  need;
      logic [3:0]  body;
      logic [15:0] got;
      need = m_write ? 4'd8 : 4'd7;
      body = need - 4'd2;
      if (m_cnt < body) m_crc = crc16_byte(m_crc, b);
      m_store[m_cnt[2:0]] = b;
      m_cnt = m_cnt + 4'd1;
      if (m_cnt < need) return;
      got = m_write ? {m_store[7], m_store[6]} : {m_store[6], m_store[5]};
      if (got != m_crc) fail_txn(ST_CRC);
      else if (m_store[0] != cfg_dev || m_store[1] != (m_write ? FC_WRITE : FC_READ))
         fail_txn(ST_FRAME);
      else if (m_write) end_txn(ST_OK, 16'h0);
      else if (m_store[2] != BYTE_CNT) fail_txn(ST_FRAME);
      else end_txn(ST_OK, {m_store[3], m_store[4]});
   endfunction

   function automatic void predict_item(req_type r);
      case (func_type'(r.func))
         FUNC_READ, FUNC_WRITE: begin
            if (m_phase != PH_IDLE) push_rsp(KIND_REJECT, 8'h00, 1'b0, ST_OK, 16'h0, 3'd0);
            else begin
               m_write = (r.func == FUNC_WRITE);
               m_reg = r.target_addr;
               m_data = m_write ? r.write_value : 16'h0;
               m_att = '0;
               emit_frame();
            end
         end
         FUNC_BYTE: if (m_phase == PH_AWAIT) take_rx(r.rx_byte);
         default: begin
            if (m_phase == PH_AWAIT) begin
               if (m_timer != 16'hFFFF) m_timer++;
               if (m_timer > cfg_timeout || m_timer == 16'hFFFF) fail_txn(ST_TIMEOUT);
            end else if (m_phase == PH_GAP) begin
               if (m_timer != 16'hFFFF) m_timer++;
               if (m_timer >= cfg_gap || m_timer == 16'hFFFF) emit_frame();
            end
         end
      endcase
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // input side: bursts and gaps; prediction at each transfer
   always @(posedge clock) begin
      int n;
      cycles++;
      if (cycles > 3000000) begin
         $display("TB_ERROR");
         $finish;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            n = expected_rsp_q.size();
            predict_item(cur.d);
            if (cur.chk && (expected_rsp_q.size() == n || expected_rsp_q[n] != cur.first)) begin
               $error("table row mismatch for func %0d", cur.d.func);
               errors++;
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (stim_q.size() > 0) begin
            cur = stim_q.pop_front();
            req_valid <= 1'b1;
            req_data <= cur.d;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: stall pattern and checking
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected transfer %h", rsp_data);
               errors++;
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_data.kind != e.kind) begin
                  $error("kind exp %0h got %0h", e.kind, rsp_data.kind); errors++;
               end
               if (rsp_data.tx_byte != e.tx_byte) begin
                  $error("tx_byte exp %0h got %0h", e.tx_byte, rsp_data.tx_byte); errors++;
               end
               if (rsp_data.last != e.last) begin
                  $error("last exp %0h got %0h", e.last, rsp_data.last); errors++;
               end
               if (rsp_data.status != e.status) begin
                  $error("status exp %0h got %0h", e.status, rsp_data.status); errors++;
               end
               if (rsp_data.read_value != e.read_value) begin
                  $error("read_value exp %0h got %0h", e.read_value, rsp_data.read_value);
                  errors++;
               end
               if (rsp_data.attempts_used != e.attempts_used) begin
                  $error("attempts_used exp %0h got %0h", e.attempts_used,
                         rsp_data.attempts_used);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_left = hold_cycles;
            hold_cycles = 0;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end else mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   function automatic req_type make_req(func_type f);
      req_type r;
      r.func = f;
      r.target_addr = 16'($urandom);
      r.write_value = 16'($urandom);
      r.rx_byte = 8'($urandom);
      return r;
   endfunction

   function automatic void push_item(req_type r);
      stim_type s;
      s.d = r;
      s.chk = 0;
      s.first = '0;
      stim_q.push_back(s);
   endfunction

   function automatic void push_byte(logic [7:0] b);
      req_type r;
      r = make_req(FUNC_BYTE);
      r.rx_byte = b;
      push_item(r);
   endfunction

   // reply frame; mode 0 good, 1 bad crc, 2 bad address, 3 bad function code,
   // 4 bad byte count, 5 cut short
   function automatic void push_reply(bit wr, int mode, bit ticks);
      logic [7:0]  b [$];
      logic [15:0] c;
      b.push_back(mode == 2 ? cfg_dev ^ 8'($urandom_range(1, 255)) : cfg_dev);
      b.push_back((wr ? FC_WRITE : FC_READ) ^ (mode == 3 ? 8'($urandom_range(1, 255)) : 8'h00));
      if (wr) begin
         for (int i = 0; i < 4; i++) b.push_back(8'($urandom));
      end else begin
         b.push_back(BYTE_CNT ^ (mode == 4 ? 8'($urandom_range(1, 255)) : 8'h00));
         b.push_back(8'($urandom));
         b.push_back(8'($urandom));
      end
      c = CRC_INIT;
      foreach (b[i]) c = crc16_byte(c, b[i]);
      b.push_back(c[7:0]);
      b.push_back(c[15:8]);
      if (mode == 1) b[$urandom_range(0, b.size() - 1)] ^= 8'($urandom_range(1, 255));
      if (mode == 5) repeat ($urandom_range(1, 3)) void'(b.pop_back());
      foreach (b[i]) begin
         push_byte(b[i]);
         if (ticks && $urandom_range(0, 5) == 0) push_item(make_req(FUNC_TICK));
      end
   endfunction

   task automatic wait_sent();
      @(posedge clock);
      #1;
      while (stim_q.size() != 0 || req_valid) begin
         @(posedge clock);
         #1;
      end
   endtask

   task automatic wait_drained();
      wait_sent();
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type i, logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= i;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (i)
         CSR_DEV_ADDR:  cfg_dev = v[7:0];
         CSR_TIMEOUT:   cfg_timeout = v;
         CSR_MAX_ATT:   cfg_att = v[2:0];
         default:       cfg_gap = v;
      endcase
   endtask

   task automatic set_cfg(logic [7:0] dev, logic [15:0] tmo, logic [2:0] att, logic [15:0] gap);
      wait_drained();
      csr_write(CSR_DEV_ADDR, {8'h00, dev});
      csr_write(CSR_TIMEOUT, tmo);
      csr_write(CSR_MAX_ATT, {13'h0, att});
      csr_write(CSR_RETRY_GAP, gap);
   endtask

   // clean: only good replies and no ticks, for settings where ticks would take forever
   task automatic run_txns(int n, bit clean);
      bit wr;
      int mode;
      for (int t = 0; t < n; t++) begin
         if (!clean && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3))
               push_item(make_req($urandom_range(0, 1) ? FUNC_TICK : FUNC_BYTE));
         end
         wr = 1'($urandom_range(0, 1));
         push_item(make_req(wr ? FUNC_WRITE : FUNC_READ));
         if ($urandom_range(0, 4) == 0) push_item(make_req(func_type'($urandom_range(0, 1))));
         mode = clean ? 0 : ($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 5));
         push_reply(wr, mode, !clean);
         wait_sent();
         while (m_phase != PH_IDLE) begin
            if (m_phase == PH_GAP) begin
               repeat (cfg_gap - m_timer) push_item(make_req(FUNC_TICK));
            end else if (!clean && cfg_timeout <= 200 && $urandom_range(0, 2) == 0) begin
               repeat (cfg_timeout + 1 - m_timer) push_item(make_req(FUNC_TICK));
            end else begin
               mode = clean ? 0 : ($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 5));
               push_reply(m_write, mode, !clean);
            end
            wait_sent();
         end
      end
   endtask

   function automatic void add_row(req_type r, bit chk, rsp_type first);
      stim_type s;
      s.d = r;
      s.chk = chk;
      s.first = first;
      stim_q.push_back(s);
   endfunction

   initial begin
      req_type     r;
      logic [7:0]  fr [$];
      logic [15:0] c;
      stim_type    tbl [$];

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_DEV_ADDR;
      csr_wdata = '0;
      cfg_dev = 8'd1;
      cfg_timeout = 16'd500;
      cfg_att = 3'd3;
      cfg_gap = 16'd50;
      m_phase = PH_IDLE;
      m_write = 0;
      m_reg = '0;
      m_data = '0;
      m_cnt = '0;
      m_timer = '0;
      m_att = '0;
      m_crc = CRC_INIT;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table, run at reset settings
      r = make_req(FUNC_TICK);
      add_row(r, 1'b0, '0);
      r = make_req(FUNC_READ);
      r.target_addr = 16'h0000;
      add_row(r, 1'b1, '{KIND_TX, 8'h01, 1'b0, ST_OK, 16'h0, 3'd0});
      r = make_req(FUNC_WRITE);
      add_row(r, 1'b1, '{KIND_REJECT, 8'h00, 1'b0, ST_OK, 16'h0, 3'd0});
      fr = '{8'h01, FC_READ, BYTE_CNT, 8'hFF, 8'hFF};
      c = CRC_INIT;
      foreach (fr[i]) c = crc16_byte(c, fr[i]);
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      foreach (fr[i]) begin
         r = make_req(FUNC_BYTE);
         r.rx_byte = fr[i];
         add_row(r, i == 6, '{KIND_DONE, 8'h00, 1'b0, ST_OK, 16'hFFFF, 3'd1});
      end
      r = make_req(FUNC_WRITE);
      r.target_addr = 16'hFFFF;
      r.write_value = 16'hFFFF;
      add_row(r, 1'b1, '{KIND_TX, 8'h01, 1'b0, ST_OK, 16'h0, 3'd0});
      fr = '{8'h01, FC_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      c = CRC_INIT;
      foreach (fr[i]) c = crc16_byte(c, fr[i]);
      fr.push_back(c[7:0] ^ 8'h01);
      fr.push_back(c[15:8]);
      foreach (fr[i]) begin
         r = make_req(FUNC_BYTE);
         r.rx_byte = fr[i];
         add_row(r, i == 7, '{KIND_DONE, 8'h00, 1'b0, ST_CRC, 16'h0, 3'd1});
      end
      r = make_req(FUNC_WRITE);
      add_row(r, 1'b0, '0);
      fr = '{8'h01, FC_READ, 8'h00, 8'h00, 8'h00, 8'h00};
      c = CRC_INIT;
      foreach (fr[i]) c = crc16_byte(c, fr[i]);
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      foreach (fr[i]) begin
         r = make_req(FUNC_BYTE);
         r.rx_byte = fr[i];
         add_row(r, i == 7, '{KIND_DONE, 8'h00, 1'b0, ST_FRAME, 16'h0, 3'd1});
      end
      tbl = stim_q;
      stim_q = {};
      foreach (tbl[i]) stim_q.push_back(tbl[i]);
      wait_sent();

      run_txns(3, 1'b0);
      set_cfg(8'h00, 16'd1, 3'd1, 16'd0);
      run_txns(4, 1'b0);
      set_cfg(8'hFF, 16'hFFFF, 3'd7, 16'hFFFF);
      run_txns(3, 1'b1);
      set_cfg(8'($urandom), 16'($urandom_range(5, 40)), 3'd7, 16'd0);
      run_txns(4, 1'b0);
      // receiver holds off long while starts keep coming
      set_cfg(8'($urandom), 16'($urandom_range(3, 20)), 3'd2, 16'($urandom_range(1, 10)));
      hold_cycles = 400;
      run_txns(4, 1'b0);
      for (int p = 0; p < 4; p++) begin
         set_cfg(8'($urandom), 16'($urandom_range(2, 60)), 3'($urandom_range(1, 7)),
                 16'($urandom_range(0, 20)));
         run_txns(2, 1'b0);
      end
      wait_drained();

      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
